/* design/palette_cycling_pixel_expander_unit_macros.svh */
// Assertion macros shared by the palette expander modules.
// Each macro expects clk and rst_n in scope of the using module.
`ifndef PALETTE_CYCLING_PIXEL_EXPANDER_UNIT_MACROS_SVH
`define PALETTE_CYCLING_PIXEL_EXPANDER_UNIT_MACROS_SVH

// Same-cycle implication.
`define PCPE_ASSERT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define PCPE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* design/pcpe_pkg.sv */
// Shared types, constants and lookup functions of the palette expander.
// Used by every module of the block but pcpe_ram; depends on nothing.
package pcpe_pkg;

  localparam int ANIM_COUNT    = 5;
  localparam int BUILTIN_ANIMS = 5;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int PAL_DEPTH     = 256;
  localparam int PAL_WIDTH     = 24;

  localparam logic [1:0] CFG_ANIM  = 2'd0;
  localparam logic [1:0] CFG_FRAME = 2'd1;
  localparam logic [1:0] CFG_GAMMA = 2'd2;

  localparam logic [2:0] ANIM_SLIME   = 3'd0;
  localparam logic [2:0] ANIM_MONITOR = 3'd1;
  localparam logic [2:0] ANIM_FIRE    = 3'd2;
  localparam logic [2:0] ANIM_SHORE   = 3'd3;
  localparam logic [2:0] ANIM_BLINK   = 3'd4;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_CLEAR,
    KIND_CYCLE,
    KIND_MAIN
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  idx;
    logic [23:0] color;
    logic        wrap;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [2:0] anim;
    logic [7:0] frame;
    logic [3:0] gamma;
  } cfg_t;

  function automatic logic [7:0] anim_offset(logic [2:0] a);
    logic [7:0] r;
    unique case (a)
      ANIM_SLIME:   r = 8'd229;
      ANIM_MONITOR: r = 8'd233;
      ANIM_FIRE:    r = 8'd238;
      ANIM_SHORE:   r = 8'd248;
      ANIM_BLINK:   r = 8'd254;
      default:      r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] anim_length(logic [2:0] a);
    logic [3:0] r;
    unique case (a)
      ANIM_SLIME:   r = 4'd4;
      ANIM_MONITOR: r = 4'd5;
      ANIM_FIRE:    r = 4'd10;
      ANIM_SHORE:   r = 4'd6;
      ANIM_BLINK:   r = 4'd1;
      default:      r = 4'd1;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] anim_base(logic [2:0] a);
    logic [4:0] r;
    unique case (a)
      ANIM_SLIME:   r = 5'd0;
      ANIM_MONITOR: r = 5'd4;
      ANIM_FIRE:    r = 5'd9;
      ANIM_SHORE:   r = 5'd19;
      ANIM_BLINK:   r = 5'd25;
      default:      r = 5'd0;
    endcase
    return r;
  endfunction

  // frame mod length; quotients by reciprocal multiply, exact for 8-bit frames
  function automatic logic [3:0] frame_mod(logic [7:0] f, logic [2:0] a);
    logic [15:0] p;
    logic [7:0]  q;
    logic [7:0]  r;
    p = 16'd0;
    q = 8'd0;
    r = 8'd0;
    unique case (a)
      ANIM_SLIME: r = {6'd0, f[1:0]};
      ANIM_MONITOR: begin
        p = 16'(f) * 16'd205;
        q = {2'd0, p[15:10]};
        r = f - ({q[5:0], 2'b00} + q);
      end
      ANIM_FIRE: begin
        p = 16'(f) * 16'd205;
        q = {3'd0, p[15:11]};
        r = f - ({q[4:0], 3'b000} + {q[6:0], 1'b0});
      end
      ANIM_SHORE: begin
        p = 16'(f) * 16'd171;
        q = {2'd0, p[15:10]};
        r = f - ({q[5:0], 2'b00} + {q[6:0], 1'b0});
      end
      default: r = 8'd0;
    endcase
    return r[3:0];
  endfunction

  function automatic logic [23:0] cycle_color(logic [4:0] i);
    logic [23:0] c;
    unique case (i)
      5'd0:  c = {8'd0,   8'd108, 8'd0};
      5'd1:  c = {8'd11,  8'd115, 8'd7};
      5'd2:  c = {8'd27,  8'd123, 8'd15};
      5'd3:  c = {8'd43,  8'd131, 8'd27};
      5'd4:  c = {8'd107, 8'd107, 8'd111};
      5'd5:  c = {8'd99,  8'd103, 8'd127};
      5'd6:  c = {8'd87,  8'd107, 8'd143};
      5'd7:  c = {8'd0,   8'd147, 8'd163};
      5'd8:  c = {8'd107, 8'd187, 8'd255};
      5'd9:  c = {8'd255, 8'd0,   8'd0};
      5'd10: c = {8'd215, 8'd0,   8'd0};
      5'd11: c = {8'd147, 8'd43,  8'd11};
      5'd12: c = {8'd255, 8'd119, 8'd0};
      5'd13: c = {8'd255, 8'd59,  8'd0};
      5'd14: c = {8'd71,  8'd0,   8'd0};
      5'd15: c = {8'd123, 8'd0,   8'd0};
      5'd16: c = {8'd179, 8'd0,   8'd0};
      5'd17: c = {8'd123, 8'd0,   8'd0};
      5'd18: c = {8'd71,  8'd0,   8'd0};
      5'd19: c = {8'd83,  8'd63,  8'd43};
      5'd20: c = {8'd75,  8'd59,  8'd43};
      5'd21: c = {8'd67,  8'd55,  8'd39};
      5'd22: c = {8'd63,  8'd51,  8'd39};
      5'd23: c = {8'd55,  8'd47,  8'd35};
      5'd24: c = {8'd51,  8'd43,  8'd35};
      5'd25: c = {8'd252, 8'd0,   8'd0};
      default: c = 24'd0;
    endcase
    return c;
  endfunction

endpackage

/* design/pcpe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcpe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/pcpe_front.sv */
// Front end: accepts input transactions and classifies each one.
// Depends on pcpe_pkg for the animation tables and item type.
module pcpe_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_command,
  input  logic [7:0]      in_pixel_index,
  input  logic [7:0]      in_entry_red,
  input  logic [7:0]      in_entry_green,
  input  logic [7:0]      in_entry_blue,
  input  logic            in_last_in_frame,
  input  pcpe_pkg::cfg_t  cfg,
  input  logic            q_full,
  output logic            push,
  output pcpe_pkg::item_t item
);

  logic       anim_ok;
  logic [7:0] off;
  logic [3:0] len;
  logic [8:0] rel;
  logic       in_range;
  logic [3:0] fm;
  logic [4:0] pos_sum;
  logic [4:0] pos;
  logic [4:0] tidx;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    anim_ok  = (32'(cfg.anim) < pcpe_pkg::ANIM_COUNT) &&
               (32'(cfg.anim) < pcpe_pkg::BUILTIN_ANIMS);
    off      = pcpe_pkg::anim_offset(cfg.anim);
    len      = pcpe_pkg::anim_length(cfg.anim);
    rel      = {1'b0, in_pixel_index} - {1'b0, off};
    in_range = anim_ok && !rel[8] && (rel[7:0] <= {4'd0, len});
    fm       = pcpe_pkg::frame_mod(cfg.frame, cfg.anim);
    // rebased index is at most one length, frame remainder below one length
    pos_sum  = {1'b0, rel[3:0]} + {1'b0, fm};
    pos      = (pos_sum >= {1'b0, len}) ? (pos_sum - {1'b0, len}) : pos_sum;
    tidx     = pcpe_pkg::anim_base(cfg.anim) + pos;

    item.idx   = in_pixel_index;
    item.last  = in_last_in_frame;
    item.wrap  = (cfg.anim == pcpe_pkg::ANIM_SLIME) || (cfg.anim == pcpe_pkg::ANIM_SHORE);
    item.color = 24'd0;
    priority if (in_command) begin
      item.kind  = pcpe_pkg::KIND_WRITE;
      item.color = {in_entry_red, in_entry_green, in_entry_blue};
    end else if (in_pixel_index == 8'd0) begin
      item.kind = pcpe_pkg::KIND_CLEAR;
    end else if (in_range) begin
      item.kind  = pcpe_pkg::KIND_CYCLE;
      item.color = pcpe_pkg::cycle_color(tidx);
    end else begin
      item.kind = pcpe_pkg::KIND_MAIN;
    end
  end

endmodule

/* design/pcpe_queue.sv */
// Short FIFO of classified items between the front end and the back end.
// Depends on pcpe_pkg for the item type and depth.
`include "palette_cycling_pixel_expander_unit_macros.svh"

module pcpe_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pcpe_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output pcpe_pkg::item_t head
);

  pcpe_pkg::item_t                entry_r [pcpe_pkg::QUEUE_DEPTH];
  logic [pcpe_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [pcpe_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [pcpe_pkg::QCNT_W-1:0]    count_r, count_nxt;
  logic                           do_push;
  logic                           do_pop;

  assign full    = (count_r == pcpe_pkg::QCNT_W'(pcpe_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == pcpe_pkg::QPTR_W'(pcpe_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == pcpe_pkg::QPTR_W'(pcpe_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  `PCPE_ASSERT(a_count_bound, 1'b1, count_r <= pcpe_pkg::QCNT_W'(pcpe_pkg::QUEUE_DEPTH), "queue count above depth")
  `PCPE_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_r == $past(count_r) + 1'b1, "queue count missed a push")
  `PCPE_ASSERT(a_ptr_gap, 1'b1, (count_r == '0 || count_r == pcpe_pkg::QCNT_W'(pcpe_pkg::QUEUE_DEPTH)) == (wr_ptr_r == rd_ptr_r), "queue pointers disagree with count")

endmodule

/* design/pcpe_back.sv */
// Back end: executes queued items, owns the main palette and the output register.
// Depends on pcpe_pkg and pcpe_ram.
`include "palette_cycling_pixel_expander_unit_macros.svh"

module pcpe_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  pcpe_pkg::item_t head,
  output logic            pop,
  input  logic [3:0]      gamma,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [7:0]      out_alpha,
  output logic            out_end_of_frame
);

  logic            s1_v_r, s1_v_nxt;
  pcpe_pkg::kind_t s1_kind_r;
  logic [23:0]     s1_color_r;
  logic            s1_wrap_r;
  logic            s1_last_r;
  logic            out_valid_r, out_valid_nxt;
  logic [23:0]     out_rgb_r, out_rgb_nxt;
  logic [7:0]      out_alpha_r, out_alpha_nxt;
  logic            out_eof_r;
  logic            out_adv;
  logic            s1_adv;
  logic            ram_we;
  logic            ram_re;
  logic [23:0]     ram_rdata;

  function automatic logic [7:0] gain_sat(logic [7:0] c, logic [3:0] g);
    logic [11:0] p;
    p = 12'(c) * 12'(g);
    return (p > 12'd255) ? 8'hff : p[7:0];
  endfunction

  function automatic logic [7:0] gain_wrap(logic [7:0] c, logic [3:0] g);
    logic [11:0] p;
    p = 12'(c) * 12'(g);
    return p[9:2];
  endfunction

  assign out_adv = !out_valid_r || !out_stall;
  assign s1_adv  = !s1_v_r || out_adv;
  assign pop     = q_valid && s1_adv;
  assign ram_we  = pop && (head.kind == pcpe_pkg::KIND_WRITE);
  assign ram_re  = pop && (head.kind == pcpe_pkg::KIND_MAIN);

  pcpe_ram #(
    .WIDTH (pcpe_pkg::PAL_WIDTH),
    .DEPTH (pcpe_pkg::PAL_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head.idx),
    .wdata (head.color),
    .re    (ram_re),
    .raddr (head.idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_adv) begin
      // writes finish in the palette and leave the stage empty
      s1_v_nxt = pop && (head.kind != pcpe_pkg::KIND_WRITE);
    end

    out_valid_nxt = out_valid_r;
    out_rgb_nxt   = out_rgb_r;
    out_alpha_nxt = out_alpha_r;
    if (out_adv) begin
      out_valid_nxt = s1_v_r;
      out_alpha_nxt = pcpe_pkg::ALPHA_OPAQUE;
      unique case (s1_kind_r)
        pcpe_pkg::KIND_CLEAR: begin
          out_rgb_nxt   = 24'd0;
          out_alpha_nxt = 8'd0;
        end
        pcpe_pkg::KIND_CYCLE: begin
          if (s1_wrap_r) begin
            out_rgb_nxt = {gain_wrap(s1_color_r[23:16], gamma),
                           gain_wrap(s1_color_r[15:8], gamma),
                           gain_wrap(s1_color_r[7:0], gamma)};
          end else begin
            out_rgb_nxt = s1_color_r;
          end
        end
        pcpe_pkg::KIND_MAIN: begin
          out_rgb_nxt = {gain_sat(ram_rdata[23:16], gamma),
                         gain_sat(ram_rdata[15:8], gamma),
                         gain_sat(ram_rdata[7:0], gamma)};
        end
        default: out_rgb_nxt = 24'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_kind_r  <= head.kind;
      s1_color_r <= head.color;
      s1_wrap_r  <= head.wrap;
      s1_last_r  <= head.last;
    end
    out_rgb_r   <= out_rgb_nxt;
    out_alpha_r <= out_alpha_nxt;
    if (out_adv) begin
      out_eof_r <= s1_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_red          = out_rgb_r[23:16];
  assign out_green        = out_rgb_r[15:8];
  assign out_blue         = out_rgb_r[7:0];
  assign out_alpha        = out_alpha_r;
  assign out_end_of_frame = out_eof_r;

  `PCPE_ASSERT(a_rw_excl, ram_we, !ram_re, "palette read and write in one cycle")
  `PCPE_ASSERT_NEXT(a_s1_held, s1_v_r && out_valid_r && out_stall, s1_v_r, "pending pixel dropped under stall")
  `PCPE_ASSERT_NEXT(a_out_source, !s1_v_r && !out_valid_r, !out_valid_r, "result without a pending pixel")

endmodule

/* design/palette_cycling_pixel_expander_unit.sv */
// Palette cycling pixel expander: turns palette indices into RGBA pixels.
// Channels: in_* takes one command per transaction (expand a pixel or load a
// main palette entry); out_* gives one RGBA pixel per expand command; cfg_*
// writes animation select, frame number and gamma, index 0 to 2.
// Throughput is one transaction per cycle on both sides while nothing stalls. An
// accepted expand command passes the queue, stage 1 and the output register
// before its pixel shows on out_valid; a palette load gives no result.
// The front classifies each transaction; a four-entry queue decouples it
// from the back end, which reads the palette RAM (one registered read per
// cycle) and fills the output register. out_stall holds the output register
// and the pixel behind it; in_stall rises only once the queue is full.
// Reset empties the queue and pipeline and sets animation 0, frame 0,
// gamma 1. The main palette is not cleared: load an entry before any pixel
// reads it. cfg_ready is always high; write configuration only while idle.
// Depends on pcpe_pkg, pcpe_front, pcpe_queue, pcpe_back and pcpe_ram.
module palette_cycling_pixel_expander_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_pixel_index,
  input  logic [7:0] in_entry_red,
  input  logic [7:0] in_entry_green,
  input  logic [7:0] in_entry_blue,
  input  logic       in_last_in_frame,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic       out_end_of_frame,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [2:0]      anim_r, anim_nxt;
  logic [7:0]      frame_r, frame_nxt;
  logic [3:0]      gamma_r, gamma_nxt;
  pcpe_pkg::cfg_t  cfg;
  logic            push;
  logic            q_full;
  logic            q_valid;
  logic            pop;
  pcpe_pkg::item_t front_item;
  pcpe_pkg::item_t head;

  assign cfg_ready = 1'b1;

  always_comb begin
    anim_nxt  = anim_r;
    frame_nxt = frame_r;
    gamma_nxt = gamma_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pcpe_pkg::CFG_ANIM:  anim_nxt  = cfg_data[2:0];
        pcpe_pkg::CFG_FRAME: frame_nxt = cfg_data;
        pcpe_pkg::CFG_GAMMA: gamma_nxt = cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      anim_r  <= pcpe_pkg::ANIM_SLIME;
      frame_r <= 8'd0;
      gamma_r <= 4'd1;
    end else begin
      anim_r  <= anim_nxt;
      frame_r <= frame_nxt;
      gamma_r <= gamma_nxt;
    end
  end

  assign cfg.anim  = anim_r;
  assign cfg.frame = frame_r;
  assign cfg.gamma = gamma_r;

  pcpe_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_pixel_index   (in_pixel_index),
    .in_entry_red     (in_entry_red),
    .in_entry_green   (in_entry_green),
    .in_entry_blue    (in_entry_blue),
    .in_last_in_frame (in_last_in_frame),
    .cfg              (cfg),
    .q_full           (q_full),
    .push             (push),
    .item             (front_item)
  );

  pcpe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  pcpe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .head             (head),
    .pop              (pop),
    .gamma            (cfg.gamma),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

/* test/testbench.sv */
// Self-checking testbench for palette_cycling_pixel_expander_unit.
// Queue-fed driver, clocked monitor and an in-bench pixel predictor; uses pcpe_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic       CMD_EXPAND = 1'b0;
  localparam logic       CMD_LOAD   = 1'b1;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 17;
  localparam int PHASE_ITEMS   = 100;
  localparam int SETTLE        = 10;
  localparam int LONG_HOLD     = 120;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic       command;
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_cmd_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       eof;
  } rgba_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] first;
    logic [3:0] span;
    logic [4:0] base;
  } anim_geom_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_command = 1'b0;
  logic [7:0] in_pixel_index = 8'd0;
  logic [7:0] in_entry_red = 8'd0;
  logic [7:0] in_entry_green = 8'd0;
  logic [7:0] in_entry_blue = 8'd0;
  logic       in_last_in_frame = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       out_end_of_frame;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data = 8'd0;

  palette_cycling_pixel_expander_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_pixel_index(in_pixel_index), .in_entry_red(in_entry_red),
    .in_entry_green(in_entry_green), .in_entry_blue(in_entry_blue),
    .in_last_in_frame(in_last_in_frame),
    .out_valid(out_valid), .out_stall(out_stall), .out_red(out_red),
    .out_green(out_green), .out_blue(out_blue), .out_alpha(out_alpha),
    .out_end_of_frame(out_end_of_frame),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow of the block: registers and main palette
  logic [2:0]  cur_anim = pcpe_pkg::ANIM_SLIME;
  logic [7:0]  cur_frame = 8'd0;
  logic [3:0]  cur_gain = 4'd1;
  logic [23:0] pal_shadow [256];

  pixel_cmd_t pending_cmds [$];
  rgba_t      pixels_due [$];
  bit         loaded [256];
  bit         took = 1'b0;
  bit         sender_calm = 1'b0;
  bit         recv_calm = 1'b0;
  bit         hold_req = 1'b0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  int         mismatches = 0;
  int         cycle_count = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) cycle_count++;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("testbench failed");
    $finish;
  end

  function automatic anim_geom_t anim_geom(logic [2:0] anim);
    anim_geom_t g;
    g.ok = 1'b1;
    g.first = 8'd0;
    g.span = 4'd1;
    g.base = 5'd0;
    case (anim)
      pcpe_pkg::ANIM_SLIME: begin
        g.first = 8'd229; g.span = 4'd4; g.base = 5'd0;
      end
      pcpe_pkg::ANIM_MONITOR: begin
        g.first = 8'd233; g.span = 4'd5; g.base = 5'd4;
      end
      pcpe_pkg::ANIM_FIRE: begin
        g.first = 8'd238; g.span = 4'd10; g.base = 5'd9;
      end
      pcpe_pkg::ANIM_SHORE: begin
        g.first = 8'd248; g.span = 4'd6; g.base = 5'd19;
      end
      pcpe_pkg::ANIM_BLINK: begin
        g.first = 8'd254; g.span = 4'd1; g.base = 5'd25;
      end
      default: g.ok = 1'b0;
    endcase
    if (int'(anim) >= pcpe_pkg::ANIM_COUNT) g.ok = 1'b0;
    return g;
  endfunction

  function automatic logic [23:0] cycle_rgb(int i);
    logic [23:0] c;
    case (i)
      0:  c = {8'd0,   8'd108, 8'd0};
      1:  c = {8'd11,  8'd115, 8'd7};
      2:  c = {8'd27,  8'd123, 8'd15};
      3:  c = {8'd43,  8'd131, 8'd27};
      4:  c = {8'd107, 8'd107, 8'd111};
      5:  c = {8'd99,  8'd103, 8'd127};
      6:  c = {8'd87,  8'd107, 8'd143};
      7:  c = {8'd0,   8'd147, 8'd163};
      8:  c = {8'd107, 8'd187, 8'd255};
      9:  c = {8'd255, 8'd0,   8'd0};
      10: c = {8'd215, 8'd0,   8'd0};
      11: c = {8'd147, 8'd43,  8'd11};
      12: c = {8'd255, 8'd119, 8'd0};
      13: c = {8'd255, 8'd59,  8'd0};
      14: c = {8'd71,  8'd0,   8'd0};
      15: c = {8'd123, 8'd0,   8'd0};
      16: c = {8'd179, 8'd0,   8'd0};
      17: c = {8'd123, 8'd0,   8'd0};
      18: c = {8'd71,  8'd0,   8'd0};
      19: c = {8'd83,  8'd63,  8'd43};
      20: c = {8'd75,  8'd59,  8'd43};
      21: c = {8'd67,  8'd55,  8'd39};
      22: c = {8'd63,  8'd51,  8'd39};
      23: c = {8'd55,  8'd47,  8'd35};
      24: c = {8'd51,  8'd43,  8'd35};
      25: c = {8'd252, 8'd0,   8'd0};
      default: c = 24'd0;
    endcase
    return c;
  endfunction

  function automatic bit in_cycle(logic [7:0] idx, logic [2:0] anim);
    anim_geom_t g;
    g = anim_geom(anim);
    return g.ok && idx >= g.first && int'(idx - g.first) <= int'(g.span);
  endfunction

  function automatic bit needs_palette(logic [7:0] idx);
    return idx != 8'd0 && !in_cycle(idx, cur_anim);
  endfunction

  function automatic logic [7:0] wrap_gain(logic [7:0] c);
    int v;
    v = (int'(c) * int'(cur_gain)) >> 2;
    return v[7:0];
  endfunction

  function automatic logic [7:0] sat_gain(logic [7:0] c);
    int v;
    v = int'(c) * int'(cur_gain);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic rgba_t expand_pixel(logic [7:0] idx, logic last);
    anim_geom_t  g;
    rgba_t       px;
    logic [23:0] c;
    int          pos;
    g = anim_geom(cur_anim);
    px.eof = last;
    px.alpha = pcpe_pkg::ALPHA_OPAQUE;
    if (idx == 8'd0) begin
      px.red = 8'd0;
      px.green = 8'd0;
      px.blue = 8'd0;
      px.alpha = 8'd0;
    end else if (in_cycle(idx, cur_anim)) begin
      pos = (int'(idx - g.first) + int'(cur_frame)) % int'(g.span);
      c = cycle_rgb(int'(g.base) + pos);
      if (cur_anim == pcpe_pkg::ANIM_SLIME || cur_anim == pcpe_pkg::ANIM_SHORE) begin
        px.red = wrap_gain(c[23:16]);
        px.green = wrap_gain(c[15:8]);
        px.blue = wrap_gain(c[7:0]);
      end else begin
        px.red = c[23:16];
        px.green = c[15:8];
        px.blue = c[7:0];
      end
    end else begin
      c = pal_shadow[idx];
      px.red = sat_gain(c[23:16]);
      px.green = sat_gain(c[15:8]);
      px.blue = sat_gain(c[7:0]);
    end
    return px;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int idle_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] rand_color();
    if ($urandom_range(0, 1) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 31));
  endfunction

  function automatic logic rand_last();
    return $urandom_range(0, 7) == 0;
  endfunction

  // Accept side: predict at the edge that takes the transaction
  always @(posedge clk) begin
    pixel_cmd_t cmd;
    if (rst_n && in_valid && !in_stall) begin
      cmd = pending_cmds.pop_front();
      took = 1'b1;
      if (cmd.command == CMD_LOAD) pal_shadow[cmd.index] = {cmd.red, cmd.green, cmd.blue};
      else pixels_due.push_back(expand_pixel(cmd.index, cmd.last));
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || took) begin
      if (took) gap_left = idle_len(sender_calm);
      took = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        in_valid <= 1'b1;
        in_command <= pending_cmds[0].command;
        in_pixel_index <= pending_cmds[0].index;
        in_entry_red <= pending_cmds[0].red;
        in_entry_green <= pending_cmds[0].green;
        in_entry_blue <= pending_cmds[0].blue;
        in_last_in_frame <= pending_cmds[0].last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = idle_len(recv_calm);
        if (stall_left > 0) begin
          stall_left--;
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    rgba_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pixels_due.size() == 0) begin
        $display("%0t ns: unexpected pixel, expected none, actual r=%0d g=%0d b=%0d a=%0d eof=%0d",
                 $time, out_red, out_green, out_blue, out_alpha, out_end_of_frame);
        mismatches++;
      end else begin
        want = pixels_due.pop_front();
        check_field("red", want.red, out_red);
        check_field("green", want.green, out_green);
        check_field("blue", want.blue, out_blue);
        check_field("alpha", want.alpha, out_alpha);
        check_field("end_of_frame", want.eof, out_end_of_frame);
      end
    end
  end

  task automatic add_load(logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_cmd_t cmd;
    cmd.command = CMD_LOAD;
    cmd.index = idx;
    cmd.red = r;
    cmd.green = g;
    cmd.blue = b;
    cmd.last = rand_last();
    loaded[idx] = 1'b1;
    pending_cmds.push_back(cmd);
  endtask

  task automatic add_pixel(logic [7:0] idx, logic last);
    pixel_cmd_t cmd;
    cmd.command = CMD_EXPAND;
    cmd.index = idx;
    cmd.red = 8'($urandom);
    cmd.green = 8'($urandom);
    cmd.blue = 8'($urandom);
    cmd.last = last;
    pending_cmds.push_back(cmd);
  endtask

  task automatic add_random_item();
    int         pick;
    logic [7:0] idx;
    anim_geom_t g;
    g = anim_geom(cur_anim);
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      idx = 8'($urandom_range(0, 255));
      add_load(idx, rand_color(), rand_color(), rand_color());
      // read straight back behind the load now and then
      if (pick < 6 && needs_palette(idx)) add_pixel(idx, rand_last());
    end else if (pick < 33) begin
      add_pixel(8'd0, rand_last());
    end else if (pick < 63 && g.ok) begin
      add_pixel(g.first + 8'($urandom_range(0, int'(g.span))), rand_last());
    end else begin
      idx = 8'($urandom_range(0, 255));
      while (needs_palette(idx) && !loaded[idx]) idx = 8'($urandom_range(0, 255));
      add_pixel(idx, rand_last());
    end
  endtask

  task automatic set_reg(logic [1:0] index, logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      pcpe_pkg::CFG_ANIM:  cur_anim = data[2:0];
      pcpe_pkg::CFG_FRAME: cur_frame = data;
      pcpe_pkg::CFG_GAMMA: cur_gain = data[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int anim_v;
    int frame_v;
    int gain_v;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: slime, frame 0, gain 1
    add_load(8'd0, 8'hff, 8'hff, 8'hff);
    add_load(8'd1, 8'hff, 8'hff, 8'hff);
    add_load(8'd228, 8'h00, 8'h00, 8'h00);
    add_load(8'd234, 8'h12, 8'h34, 8'h56);
    add_load(8'd255, 8'h80, 8'h7f, 8'h01);
    add_pixel(8'd0, 1'b0);
    add_pixel(8'd1, 1'b1);
    add_pixel(8'd228, 1'b0);
    add_pixel(8'd229, 1'b0);
    add_pixel(8'd232, 1'b0);
    add_pixel(8'd233, 1'b0);
    add_pixel(8'd234, 1'b0);
    add_pixel(8'd255, 1'b1);
    add_load(8'd100, 8'haa, 8'h55, 8'h0f);
    add_pixel(8'd100, 1'b0);
    add_load(8'd100, 8'h01, 8'h02, 8'h03);
    add_pixel(8'd100, 1'b1);
    drain();

    // Blinking red, top frame, top gain; unmapped register index is ignored
    set_reg(pcpe_pkg::CFG_ANIM, {5'b10101, pcpe_pkg::ANIM_BLINK});
    set_reg(pcpe_pkg::CFG_FRAME, 8'd255);
    set_reg(pcpe_pkg::CFG_GAMMA, 8'hef);
    set_reg(CFG_UNUSED, 8'h5a);
    @(posedge clk);
    add_load(8'd253, 8'h11, 8'h22, 8'h33);
    add_pixel(8'd253, 1'b0);
    add_pixel(8'd254, 1'b0);
    add_pixel(8'd255, 1'b1);
    add_pixel(8'd1, 1'b0);
    add_pixel(8'd0, 1'b1);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      anim_v = (p < 8) ? p : $urandom_range(0, 7);
      frame_v = (p % 3 == 0) ? 255 : (p % 3 == 1) ? 0 : $urandom_range(0, 255);
      gain_v = (p % 4 == 1) ? 0 : (p % 4 == 2) ? 15 : $urandom_range(0, 15);
      set_reg(pcpe_pkg::CFG_ANIM, {5'($urandom), 3'(anim_v)});
      set_reg(pcpe_pkg::CFG_FRAME, 8'(frame_v));
      set_reg(pcpe_pkg::CFG_GAMMA, {4'($urandom), 4'(gain_v)});
      @(posedge clk);
      sender_calm = (p == 4 || p == 9);
      recv_calm = (p == 9);
      repeat (PHASE_ITEMS) add_random_item();
      // back up the whole pipe: receiver holds while the sender keeps offering
      if (p == 4) hold_req = 1'b1;
      drain();
    end
    sender_calm = 1'b0;
    recv_calm = 1'b0;

    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
